// ===== hdl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg
// Shared widths, command codes, reciprocal constants and the month table
// of the calendar date arithmetic core.
// ----------------------------------------------------------------------------
package cda_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 21;
   localparam int DIFF_W  = 23;

   // day numbers: signed working width and unsigned start-of-year width
   localparam int DN_W  = 24;
   localparam int DS_W  = 23;
   localparam int REM_W = 9;
   localparam int EST_W = 22;

   // command codes
   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_SUB  = 2'd1;
   localparam logic [1:0] CMD_DIFF = 2'd2;

   // floor(x / 100) as (x * 5243) >> 19, exact for x below 43690
   localparam int            RECIP_100_W     = 13;
   localparam logic [12:0]   RECIP_100       = 13'd5243;
   localparam int            RECIP_100_SHIFT = 19;

   // year estimate from a day number, within one year of the truth
   localparam int            RECIP_YEAR_W     = 12;
   localparam logic [11:0]   RECIP_YEAR       = 12'd2871;
   localparam int            RECIP_YEAR_SHIFT = 20;

   // day numbers of 1 jan of year 1 and of year 10000
   localparam logic signed [DN_W-1:0] FIRST_DAY = 24'sd366;
   localparam logic signed [DN_W-1:0] END_DAY   = 24'sd3652425;

   // fields of date a and flags that ride along the pipeline
   typedef struct packed {
      logic [1:0]         command;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               earlier;
      logic               same;
   } side_type;

   // days in the year before the first of a month (index 0 is january)
   function automatic logic [REM_W-1:0] month_start(input logic [3:0] idx,
                                                    input logic leap);
      logic [REM_W-1:0] base;
      case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         default: base = 9'd334;
      endcase
      if (leap && idx >= 4'd2) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// ===== hdl/cda_req_if.sv =====
// ----------------------------------------------------------------------------
// cda_req_if
// Request channel: command, two dates and a signed day count per item.
// ----------------------------------------------------------------------------
interface cda_req_if import cda_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                command;
   logic [YEAR_W-1:0]         year_a;
   logic [MONTH_W-1:0]        month_a;
   logic [DAY_W-1:0]          day_a;
   logic [YEAR_W-1:0]         year_b;
   logic [MONTH_W-1:0]        month_b;
   logic [DAY_W-1:0]          day_b;
   logic signed [COUNT_W-1:0] day_count;

   modport source (output valid, command, year_a, month_a, day_a,
                   year_b, month_b, day_b, day_count, input ready);
   modport sink   (input valid, command, year_a, month_a, day_a,
                   year_b, month_b, day_b, day_count, output ready);
endinterface

// ===== hdl/cda_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cda_rsp_if
// Response channel: resulting date, day difference and compare flags.
// ----------------------------------------------------------------------------
interface cda_rsp_if import cda_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [YEAR_W-1:0]        result_year;
   logic [MONTH_W-1:0]       result_month;
   logic [DAY_W-1:0]         result_day;
   logic signed [DIFF_W-1:0] day_difference;
   logic                     a_before_b;
   logic                     a_same_as_b;
   logic                     out_of_range;

   modport source (output valid, result_year, result_month, result_day,
                   day_difference, a_before_b, a_same_as_b, out_of_range,
                   input ready);
   modport sink   (input valid, result_year, result_month, result_day,
                   day_difference, a_before_b, a_same_as_b, out_of_range,
                   output ready);
endinterface

// ===== hdl/cda_year_start.sv =====
// ----------------------------------------------------------------------------
// cda_year_start
// Two-stage unit: day number of 1 january of a year and its leap flag.
// ----------------------------------------------------------------------------
module cda_year_start import cda_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [YEAR_W-1:0] year,
   output logic [DS_W-1:0]   day_start,
   output logic              leap
);

   logic [YEAR_W:0]                 y3, y99, y399;
   logic [YEAR_W+RECIP_100_W:0]     p99, p399;
   logic [YEAR_W+RECIP_100_W-1:0]   ph;

   logic [DS_W-1:0]   days365_in, days365_ff;
   logic [12:0]       c4_in, c4_ff;
   logic [8:0]        c100_in, c100_ff;
   logic [6:0]        c400_in, c400_ff;
   logic [7:0]        qh_in, qh_ff;
   logic [YEAR_W-1:0] year_ff;
   logic [DS_W-1:0]   day_start_in, day_start_ff;
   logic              div100;
   logic              leap_in, leap_ff;

   // stage 1: 365 * y and the rounded-up quarter, century and 400 counts
   always_comb begin
      y3         = {1'b0, year} + (YEAR_W+1)'(3);
      y99        = {1'b0, year} + (YEAR_W+1)'(99);
      y399       = {1'b0, year} + (YEAR_W+1)'(399);
      p99        = (YEAR_W+RECIP_100_W+1)'(y99) * (YEAR_W+RECIP_100_W+1)'(RECIP_100);
      p399       = (YEAR_W+RECIP_100_W+1)'(y399) * (YEAR_W+RECIP_100_W+1)'(RECIP_100);
      ph         = (YEAR_W+RECIP_100_W)'(year) * (YEAR_W+RECIP_100_W)'(RECIP_100);
      days365_in = DS_W'(year) * DS_W'(365);
      c4_in      = y3[YEAR_W:2];
      c100_in    = p99[RECIP_100_SHIFT +: 9];
      c400_in    = p399[RECIP_100_SHIFT+2 +: 7];
      qh_in      = ph[RECIP_100_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         days365_ff <= days365_in;
         c4_ff      <= c4_in;
         c100_ff    <= c100_in;
         c400_ff    <= c400_in;
         qh_ff      <= qh_in;
         year_ff    <= year;
      end
   end

   // stage 2: sum of the terms and the leap rule
   always_comb begin
      day_start_in = days365_ff + DS_W'(c4_ff) - DS_W'(c100_ff) + DS_W'(c400_ff);
      div100       = (year_ff == YEAR_W'(YEAR_W'(qh_ff) * YEAR_W'(100)));
      leap_in      = ((year_ff[1:0] == 2'd0) && !div100) ||
                     (div100 && (qh_ff[1:0] == 2'd0));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         day_start_ff <= day_start_in;
         leap_ff      <= leap_in;
      end
   end

   assign day_start = day_start_ff;
   assign leap      = leap_ff;

endmodule

// ===== hdl/calendar_date_arithmetic_core.sv =====
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_core
// Proleptic gregorian date add, subtract, difference and compare.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: command, date a, date b and a signed day count.
//   rsp returns one item per request in request order: the resulting date,
//   the day difference a minus b, and the before / same / out-of-range flags.
//   Both channels use valid/ready; an item moves when both are high.
//   The core is a nine-stage pipeline: dates go to day numbers through a
//   two-stage year-start unit per date, the add or difference is taken, a
//   year estimate is refined among three candidates, and the month is found
//   by a table compare. A new item can enter every cycle while rsp does not
//   stall. When rsp stalls with an item waiting at the output, the whole
//   pipeline holds and req.ready drops; no item is lost or repeated.
//   Synchronous reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_core import cda_pkg::*; (
   input logic        clock,
   input logic        reset,
   cda_req_if.sink    req,
   cda_rsp_if.source  rsp
);

   localparam int STAGES = 9;

   typedef struct packed {
      side_type                  side;
      logic [YEAR_W-1:0]         year_b;
      logic [MONTH_W-1:0]        month_b;
      logic [DAY_W-1:0]          day_b;
      logic signed [COUNT_W-1:0] count;
   } front_type;

   typedef struct packed {
      side_type          side;
      logic              oor;
      logic [DIFF_W-1:0] diff;
      logic [DS_W-1:0]   t;
      logic [YEAR_W-1:0] est;
   } back_type;

   logic [STAGES-1:0] valid_in, valid_ff;
   logic              adv;

   front_type front0_in, front1_in, front0_ff, front1_ff, front2_ff;
   logic [DS_W-1:0]   ds_a, ds_b;
   logic              leap_a, leap_b;

   logic signed [DN_W-1:0]    dn_a_in, dn_b_in, dn_a3_ff, dn_b3_ff;
   side_type                  side3_ff;
   logic signed [COUNT_W-1:0] count3_ff;

   logic signed [DN_W-1:0]             count_x, net, t3;
   logic [DN_W-1:0]                    diff3;
   logic [EST_W+RECIP_YEAR_W-1:0]      est_prod;
   back_type                           back4_in, back4_ff, back5_ff, back6_ff;

   logic [YEAR_W-1:0] est_lo, est_hi;
   logic [DS_W-1:0]   ds_lo, ds_mid, ds_hi;
   logic              leap_lo, leap_mid, leap_hi;

   logic [YEAR_W-1:0] year7_in, year7_ff;
   logic [DS_W-1:0]   ys7;
   logic [REM_W-1:0]  rem7_in, rem7_ff;
   logic              leap7_in, leap7_ff;
   side_type          side7_ff;
   logic              oor7_ff;
   logic [DIFF_W-1:0] diff7_ff;

   logic [3:0]         mon_idx;
   logic [REM_W-1:0]   day_rem;
   logic [YEAR_W-1:0]  ry_in, ry_ff;
   logic [MONTH_W-1:0] rm_in, rm_ff;
   logic [DAY_W-1:0]   rd_in, rd_ff;
   logic [DIFF_W-1:0]  diff_in, diff_ff;
   logic               before_ff, same_ff, oor_in, oor_ff;

   // month field to table index, out-of-range months clamp to jan / dec
   function automatic logic [3:0] month_idx(input logic [MONTH_W-1:0] m);
      logic [3:0] idx;
      if (m == 4'd0) begin
         idx = 4'd0;
      end else if (m > 4'd12) begin
         idx = 4'd11;
      end else begin
         idx = m - 4'd1;
      end
      return idx;
   endfunction

   // whole pipeline moves unless the output item is held
   assign adv       = !valid_ff[STAGES-1] || rsp.ready;
   assign req.ready = adv;
   assign valid_in  = {valid_ff[STAGES-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // stage 0: capture item
   always_comb begin
      front0_in.side.command = req.command;
      front0_in.side.year    = req.year_a;
      front0_in.side.month   = req.month_a;
      front0_in.side.day     = req.day_a;
      front0_in.side.earlier = 1'b0;
      front0_in.side.same    = 1'b0;
      front0_in.year_b       = req.year_b;
      front0_in.month_b      = req.month_b;
      front0_in.day_b        = req.day_b;
      front0_in.count        = req.day_count;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front0_ff <= front0_in;
      end
   end

   // stages 1-2: year starts of a and b, compare flags
   cda_year_start u_start_a (
      .clock(clock), .enable(adv), .year(front0_ff.side.year),
      .day_start(ds_a), .leap(leap_a)
   );

   cda_year_start u_start_b (
      .clock(clock), .enable(adv), .year(front0_ff.year_b),
      .day_start(ds_b), .leap(leap_b)
   );

   // lexicographic compare of the raw date fields
   always_comb begin
      front1_in              = front0_ff;
      front1_in.side.same    = (front0_ff.side.year == front0_ff.year_b) &&
                               (front0_ff.side.month == front0_ff.month_b) &&
                               (front0_ff.side.day == front0_ff.day_b);
      front1_in.side.earlier = (front0_ff.side.year < front0_ff.year_b) ||
                               ((front0_ff.side.year == front0_ff.year_b) &&
                                ((front0_ff.side.month < front0_ff.month_b) ||
                                 ((front0_ff.side.month == front0_ff.month_b) &&
                                  (front0_ff.side.day < front0_ff.day_b))));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front1_ff <= front1_in;
         front2_ff <= front1_ff;
      end
   end

   // stage 2: full day numbers
   always_comb begin
      dn_a_in = DN_W'(ds_a)
              + DN_W'(month_start(month_idx(front2_ff.side.month), leap_a))
              + DN_W'(front2_ff.side.day) - DN_W'(1);
      dn_b_in = DN_W'(ds_b)
              + DN_W'(month_start(month_idx(front2_ff.month_b), leap_b))
              + DN_W'(front2_ff.day_b) - DN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dn_a3_ff  <= dn_a_in;
         dn_b3_ff  <= dn_b_in;
         side3_ff  <= front2_ff.side;
         count3_ff <= front2_ff.count;
      end
   end

   // stage 3: target day, difference, range check and year estimate
   always_comb begin
      count_x = {{(DN_W-COUNT_W){count3_ff[COUNT_W-1]}}, count3_ff};
      net     = (side3_ff.command == CMD_ADD) ? count_x : -count_x;
      t3      = dn_a3_ff + net;
      diff3   = dn_a3_ff - dn_b3_ff;
      est_prod = (EST_W+RECIP_YEAR_W)'(t3[EST_W-1:0]) *
                 (EST_W+RECIP_YEAR_W)'(RECIP_YEAR);
      back4_in.side = side3_ff;
      back4_in.oor  = (t3 < FIRST_DAY) || (t3 >= END_DAY);
      back4_in.diff = diff3[DIFF_W-1:0];
      back4_in.t    = t3[DS_W-1:0];
      back4_in.est  = est_prod[RECIP_YEAR_SHIFT +: YEAR_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         back4_ff <= back4_in;
         back5_ff <= back4_ff;
         back6_ff <= back5_ff;
      end
   end

   // stages 5-6: starts of the three candidate years
   assign est_lo = back4_ff.est - YEAR_W'(1);
   assign est_hi = back4_ff.est + YEAR_W'(1);

   cda_year_start u_start_lo (
      .clock(clock), .enable(adv), .year(est_lo),
      .day_start(ds_lo), .leap(leap_lo)
   );

   cda_year_start u_start_mid (
      .clock(clock), .enable(adv), .year(back4_ff.est),
      .day_start(ds_mid), .leap(leap_mid)
   );

   cda_year_start u_start_hi (
      .clock(clock), .enable(adv), .year(est_hi),
      .day_start(ds_hi), .leap(leap_hi)
   );

   // stage 6: pick the year holding the target day
   always_comb begin
      if (back6_ff.t < ds_mid) begin
         year7_in = back6_ff.est - YEAR_W'(1);
         ys7      = ds_lo;
         leap7_in = leap_lo;
      end else if (back6_ff.t >= ds_hi) begin
         year7_in = back6_ff.est + YEAR_W'(1);
         ys7      = ds_hi;
         leap7_in = leap_hi;
      end else begin
         year7_in = back6_ff.est;
         ys7      = ds_mid;
         leap7_in = leap_mid;
      end
      rem7_in = REM_W'(back6_ff.t - ys7);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         year7_ff <= year7_in;
         rem7_ff  <= rem7_in;
         leap7_ff <= leap7_in;
         side7_ff <= back6_ff.side;
         oor7_ff  <= back6_ff.oor;
         diff7_ff <= back6_ff.diff;
      end
   end

   // stage 7: month search and result select
   always_comb begin
      mon_idx = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (rem7_ff >= month_start(4'(i), leap7_ff)) begin
            mon_idx = 4'(i);
         end
      end
      day_rem = rem7_ff - month_start(mon_idx, leap7_ff) + REM_W'(1);

      ry_in   = side7_ff.year;
      rm_in   = side7_ff.month;
      rd_in   = side7_ff.day;
      diff_in = '0;
      oor_in  = 1'b0;
      case (side7_ff.command) inside
         CMD_ADD, CMD_SUB: begin
            if (oor7_ff) begin
               oor_in = 1'b1;
            end else begin
               ry_in = year7_ff;
               rm_in = MONTH_W'(mon_idx + 4'd1);
               rd_in = day_rem[DAY_W-1:0];
            end
         end
         CMD_DIFF: begin
            diff_in = diff7_ff;
         end
         default: begin
            diff_in = '0;
         end
      endcase
   end

   // stage 8: output register
   always_ff @(posedge clock) begin
      if (adv) begin
         ry_ff     <= ry_in;
         rm_ff     <= rm_in;
         rd_ff     <= rd_in;
         diff_ff   <= diff_in;
         oor_ff    <= oor_in;
         before_ff <= side7_ff.earlier;
         same_ff   <= side7_ff.same;
      end
   end

   assign rsp.valid          = valid_ff[STAGES-1];
   assign rsp.result_year    = ry_ff;
   assign rsp.result_month   = rm_ff;
   assign rsp.result_day     = rd_ff;
   assign rsp.day_difference = diff_ff;
   assign rsp.a_before_b     = before_ff;
   assign rsp.a_same_as_b    = same_ff;
   assign rsp.out_of_range   = oor_ff;

   // a held output freezes the valid bits of every stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved while output held");

   // equal dates are never reported as earlier
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.a_same_as_b && rsp.a_before_b))
      else $error("before and same both set");

   // out of range only on add or subtract, which carry no difference
   a_oor_no_diff: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.out_of_range |-> rsp.day_difference == '0)
      else $error("difference set on out-of-range item");

   // in-range target lands inside the chosen year
   a_rem_in_year: assert property (@(posedge clock) disable iff (reset)
      valid_ff[7] && !oor7_ff &&
      (side7_ff.command == CMD_ADD || side7_ff.command == CMD_SUB)
      |-> rem7_ff <= REM_W'(365))
      else $error("year selection missed");

endmodule
